>>> src/ggnh_pkg.sv
`default_nettype none

package ggnh_pkg;

  // Field widths of the stream words.
  localparam int ADDR_W     = 16;
  localparam int POS_W      = 16;
  localparam int IDX_W      = 5;
  localparam int SQ_W       = 33;
  localparam int PROD_W     = 2 * POS_W;
  localparam int SLOT_W     = ADDR_W + 2 * POS_W;
  localparam int STATUS_W   = 2;
  localparam int IN_DATA_W  = 72;
  localparam int IN_USER_W  = 1;
  localparam int OUT_DATA_W = 16;
  localparam int OUT_USER_W = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = SQ_W;

  // The table can never hold more slots than the entry index can address.
  localparam int MAX_SLOTS = 2 ** IDX_W;

  // Bit positions of the input fields in s_tdata.
  localparam int IN_IDX_LSB   = 0;
  localparam int IN_VALID_BIT = IN_IDX_LSB + IDX_W;
  localparam int IN_ADDR_LSB  = IN_VALID_BIT + 1;
  localparam int IN_X_LSB     = IN_ADDR_LSB + ADDR_W;
  localparam int IN_Y_LSB     = IN_X_LSB + POS_W;
  localparam int IN_DEST_LSB  = IN_Y_LSB + POS_W;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  localparam logic [STATUS_W-1:0] ST_FOUND       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_NEIGHBOR = 2'd2;
  localparam logic [STATUS_W-1:0] ST_WRITE_DONE  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_SELF_ADDR       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OWN_X           = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OWN_Y           = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HOP_RANGE_SQ    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SEARCH_LIMIT_SQ = 3'd4;

  localparam logic [SQ_W-1:0] HOP_RANGE_RESET    = 33'd65536;
  localparam logic [SQ_W-1:0] SEARCH_LIMIT_RESET = 33'd1638400;

  typedef enum logic [2:0] {
    CS_IDLE,
    CS_FIND,
    CS_FIND_DRAIN,
    CS_CHOOSE,
    CS_PICK,
    CS_PICK_DRAIN1,
    CS_PICK_DRAIN2,
    CS_RESULT
  } ctrl_state_t;

  typedef struct packed {
    logic accept;    // input word taken this cycle
    logic find_rd;   // table read for the destination search
    logic pick_rd;   // table read for the neighbour search
    logic res_load;  // load the result into the output register
  } dp_cmd_t;

  typedef struct packed {
    logic dest_known;
    logic out_busy;
  } dp_status_t;

  function automatic logic [POS_W-1:0] abs_diff(input logic [POS_W-1:0] a,
                                                input logic [POS_W-1:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

`default_nettype wire

>>> src/ggnh_ram.sv
`default_nettype none

module ggnh_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> src/ggnh_ctrl.sv
`default_nettype none

module ggnh_ctrl #(
  parameter int DEPTH = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  input  wire logic                         in_action,
  output logic                              in_ready,
  input  wire ggnh_pkg::dp_status_t         status,
  output ggnh_pkg::dp_cmd_t                 cmd,
  output logic [$clog2(DEPTH)-1:0]          rd_addr
);

  localparam int AW = $clog2(DEPTH);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  ggnh_pkg::ctrl_state_t state, state_next;
  logic [AW-1:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ggnh_pkg::CS_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    cmd          = '0;
    in_ready     = 1'b0;
    rd_addr      = cnt;
    unique case (state)
      ggnh_pkg::CS_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        cnt_next   = '0;
        if (in_valid) begin
          state_next = (in_action == ggnh_pkg::ACT_QUERY) ? ggnh_pkg::CS_FIND
                                                         : ggnh_pkg::CS_RESULT;
        end
      end
      ggnh_pkg::CS_FIND: begin
        cmd.find_rd = 1'b1;
        if (cnt == LAST) begin
          cnt_next   = '0;
          state_next = ggnh_pkg::CS_FIND_DRAIN;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ggnh_pkg::CS_FIND_DRAIN: begin
        state_next = ggnh_pkg::CS_CHOOSE;
      end
      ggnh_pkg::CS_CHOOSE: begin
        state_next = status.dest_known ? ggnh_pkg::CS_PICK : ggnh_pkg::CS_RESULT;
      end
      ggnh_pkg::CS_PICK: begin
        cmd.pick_rd = 1'b1;
        if (cnt == LAST) begin
          cnt_next   = '0;
          state_next = ggnh_pkg::CS_PICK_DRAIN1;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ggnh_pkg::CS_PICK_DRAIN1: begin
        state_next = ggnh_pkg::CS_PICK_DRAIN2;
      end
      ggnh_pkg::CS_PICK_DRAIN2: begin
        state_next = ggnh_pkg::CS_RESULT;
      end
      ggnh_pkg::CS_RESULT: begin
        if (!status.out_busy) begin
          cmd.res_load = 1'b1;
          state_next   = ggnh_pkg::CS_IDLE;
        end
      end
      default: begin
        state_next = ggnh_pkg::CS_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> src/ggnh_dpath.sv
`default_nettype none

module ggnh_dpath #(
  parameter int DEPTH = 32
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire ggnh_pkg::dp_cmd_t                   cmd,
  input  wire logic [$clog2(DEPTH)-1:0]            rd_addr,
  output ggnh_pkg::dp_status_t                     status,
  input  wire logic [ggnh_pkg::IN_DATA_W-1:0]      in_data,
  input  wire logic                                in_action,
  input  wire logic                                cfg_we,
  input  wire logic [ggnh_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [ggnh_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [ggnh_pkg::OUT_DATA_W-1:0]          out_data,
  output logic [ggnh_pkg::OUT_USER_W-1:0]          out_user
);

  localparam int AW  = $clog2(DEPTH);
  localparam int AD  = ggnh_pkg::ADDR_W;
  localparam int PW  = ggnh_pkg::POS_W;
  localparam int SW  = ggnh_pkg::SQ_W;
  localparam int PRW = ggnh_pkg::PROD_W;

  // Configuration registers.
  logic [AD-1:0] self_addr;
  logic [PW-1:0] own_x, own_y;
  logic [SW-1:0] hop_range_sq, search_limit_sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      self_addr       <= '0;
      own_x           <= '0;
      own_y           <= '0;
      hop_range_sq    <= ggnh_pkg::HOP_RANGE_RESET;
      search_limit_sq <= ggnh_pkg::SEARCH_LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ggnh_pkg::REG_SELF_ADDR:       self_addr       <= cfg_data[AD-1:0];
        ggnh_pkg::REG_OWN_X:           own_x           <= cfg_data[PW-1:0];
        ggnh_pkg::REG_OWN_Y:           own_y           <= cfg_data[PW-1:0];
        ggnh_pkg::REG_HOP_RANGE_SQ:    hop_range_sq    <= cfg_data;
        ggnh_pkg::REG_SEARCH_LIMIT_SQ: search_limit_sq <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input word fields.
  logic [ggnh_pkg::IDX_W-1:0] in_idx;
  logic                       in_entry_valid;
  logic [AD-1:0]              in_addr, in_dest;
  logic [PW-1:0]              in_x, in_y;
  logic                       in_range, tbl_we;

  assign in_idx         = in_data[ggnh_pkg::IN_IDX_LSB +: ggnh_pkg::IDX_W];
  assign in_entry_valid = in_data[ggnh_pkg::IN_VALID_BIT];
  assign in_addr        = in_data[ggnh_pkg::IN_ADDR_LSB +: AD];
  assign in_x           = in_data[ggnh_pkg::IN_X_LSB +: PW];
  assign in_y           = in_data[ggnh_pkg::IN_Y_LSB +: PW];
  assign in_dest        = in_data[ggnh_pkg::IN_DEST_LSB +: AD];
  assign in_range       = 32'(in_idx) < DEPTH;
  assign tbl_we         = cmd.accept && (in_action == ggnh_pkg::ACT_WRITE) && in_range;

  // Slot table: valid bits in flip-flops, node data in the RAM.
  logic [DEPTH-1:0]               slot_valid;
  logic [ggnh_pkg::SLOT_W-1:0]    rd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else if (tbl_we) begin
      slot_valid[in_idx[AW-1:0]] <= in_entry_valid;
    end
  end

  ggnh_ram #(
    .WIDTH (ggnh_pkg::SLOT_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (in_idx[AW-1:0]),
    .wdata ({in_y, in_x, in_addr}),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  logic [AD-1:0] slot_addr;
  logic [PW-1:0] slot_x, slot_y;
  assign slot_addr = rd_data[AD-1:0];
  assign slot_x    = rd_data[AD +: PW];
  assign slot_y    = rd_data[AD+PW +: PW];

  // Read tags, aligned with the registered RAM output.
  logic tag1_find, tag1_pick, tag2_pick, v1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tag1_find <= 1'b0;
      tag1_pick <= 1'b0;
      tag2_pick <= 1'b0;
    end else begin
      tag1_find <= cmd.find_rd;
      tag1_pick <= cmd.pick_rd;
      tag2_pick <= tag1_pick;
    end
  end

  always_ff @(posedge clk) begin
    v1 <= slot_valid[rd_addr];
  end

  // Query state.
  logic          query;
  logic [AD-1:0] dest;
  logic          dest_known;
  logic [PW-1:0] dest_x, dest_y;
  logic          have_hop;
  logic [AD-1:0] hop;
  logic [SW-1:0] best;

  // Neighbour pipeline: squares of the differences, then sums and compare.
  logic [PRW-1:0] sq_own_x, sq_own_y, sq_dst_x, sq_dst_y;
  logic           ok2;
  logic [AD-1:0]  addr2;
  logic [SW-1:0]  d_own, d_dst;

  assign d_own = {1'b0, sq_own_x} + {1'b0, sq_own_y};
  assign d_dst = {1'b0, sq_dst_x} + {1'b0, sq_dst_y};

  always_ff @(posedge clk) begin
    sq_own_x <= PRW'(ggnh_pkg::abs_diff(slot_x, own_x)) *
                PRW'(ggnh_pkg::abs_diff(slot_x, own_x));
    sq_own_y <= PRW'(ggnh_pkg::abs_diff(slot_y, own_y)) *
                PRW'(ggnh_pkg::abs_diff(slot_y, own_y));
    sq_dst_x <= PRW'(ggnh_pkg::abs_diff(slot_x, dest_x)) *
                PRW'(ggnh_pkg::abs_diff(slot_x, dest_x));
    sq_dst_y <= PRW'(ggnh_pkg::abs_diff(slot_y, dest_y)) *
                PRW'(ggnh_pkg::abs_diff(slot_y, dest_y));
    ok2      <= v1 && (slot_addr != self_addr);
    addr2    <= slot_addr;
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      query      <= in_action;
      dest       <= in_dest;
      dest_known <= 1'b0;
      have_hop   <= 1'b0;
      hop        <= '0;
      best       <= search_limit_sq;
    end else begin
      // Later slots overwrite earlier ones, so the highest match wins.
      if (tag1_find && v1 && (slot_addr == dest)) begin
        dest_known <= 1'b1;
        dest_x     <= slot_x;
        dest_y     <= slot_y;
      end
      // Strictly nearer only, so on a tie the lower slot is kept.
      if (tag2_pick && ok2 && (d_own < hop_range_sq) && (d_dst < best)) begin
        best     <= d_dst;
        hop      <= addr2;
        have_hop <= 1'b1;
      end
    end
  end

  // Output register.
  logic [ggnh_pkg::STATUS_W-1:0] res_status;
  logic [AD-1:0]                 res_hop;
  logic                          res_found;

  always_comb begin
    res_status = ggnh_pkg::ST_WRITE_DONE;
    res_hop    = '0;
    res_found  = 1'b0;
    priority if (query != ggnh_pkg::ACT_QUERY) begin
      res_status = ggnh_pkg::ST_WRITE_DONE;
    end else if (!dest_known) begin
      res_status = ggnh_pkg::ST_UNKNOWN;
    end else if (have_hop) begin
      res_status = ggnh_pkg::ST_FOUND;
      res_hop    = hop;
      res_found  = 1'b1;
    end else begin
      res_status = ggnh_pkg::ST_NO_NEIGHBOR;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_data <= res_hop;
      out_user <= {res_found, res_status};
    end
  end

  assign status.dest_known = dest_known;
  assign status.out_busy   = out_valid && !out_ready;

endmodule

`default_nettype wire

>>> src/greedy_geo_next_hop_core.sv
`default_nettype none

// Greedy geographic next-hop selector. Write words fill a table of node
// addresses and Q8.8 positions; a query word looks up the destination
// position (highest matching valid slot) and then picks the valid neighbour,
// other than this node, strictly inside the hop range that is strictly
// nearest the destination and below the search limit, the lower slot winning
// a tie. Exactly one result word follows each input word. A query passes over
// the table through its one RAM read port, one slot per cycle, over D =
// min(MAX_NODES, 32) slots: once to find the destination and, only when it is
// known, once more to pick the neighbour. A new word is taken once the previous
// one has been handed to the output register, which may still be waiting for
// m_tready.
module greedy_geo_next_hop_core #(
  parameter int MAX_NODES = 32
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 s_tvalid,
  output logic                                      s_tready,
  // entry_index[4:0], entry_valid[5], entry_address[21:6], entry_x[37:22],
  // entry_y[53:38], dest_address[69:54], zero fill
  input  wire logic [ggnh_pkg::IN_DATA_W-1:0]       s_tdata,
  // action[0]
  input  wire logic [ggnh_pkg::IN_USER_W-1:0]       s_tuser,
  output logic                                      m_tvalid,
  input  wire logic                                 m_tready,
  // next_hop[15:0]
  output logic [ggnh_pkg::OUT_DATA_W-1:0]           m_tdata,
  // status[1:0], hop_found[2]
  output logic [ggnh_pkg::OUT_USER_W-1:0]           m_tuser,
  input  wire logic                                 cfg_we,
  input  wire logic [ggnh_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [ggnh_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int DEPTH = (MAX_NODES < ggnh_pkg::MAX_SLOTS) ? MAX_NODES
                                                            : ggnh_pkg::MAX_SLOTS;
  localparam int AW = $clog2(DEPTH);

  ggnh_pkg::dp_cmd_t    cmd;
  ggnh_pkg::dp_status_t status;
  logic [AW-1:0]        rd_addr;

  ggnh_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_action (s_tuser[0]),
    .in_ready  (s_tready),
    .status    (status),
    .cmd       (cmd),
    .rd_addr   (rd_addr)
  );

  ggnh_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .rd_addr   (rd_addr),
    .status    (status),
    .in_data   (s_tdata),
    .in_action (s_tuser[0]),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata),
    .out_user  (m_tuser)
  );

`ifndef SYNTH
  a_idle_no_scan: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !cmd.find_rd && !cmd.pick_rd)
    else $error("table scan running while input is accepted");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.res_load |-> !(m_tvalid && !m_tready))
    else $error("result loaded over a word still waiting");

  a_pick_known: assert property (@(posedge clk) disable iff (rst)
    cmd.pick_rd |-> status.dest_known)
    else $error("neighbour search without a known destination");
`endif

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
`default_nettype none

module tb_top;

  localparam int IDLE_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;
  localparam int PRINT_CAP = 40;

  localparam int AD = ggnh_pkg::ADDR_W;
  localparam int PW = ggnh_pkg::POS_W;
  localparam int IW = ggnh_pkg::IDX_W;
  localparam int SQ = ggnh_pkg::SQ_W;
  localparam int NS = ggnh_pkg::MAX_SLOTS;

  typedef struct {
    logic [ggnh_pkg::STATUS_W-1:0] status;
    logic [AD-1:0]                 next_hop;
    logic                          hop_found;
  } route_result_t;

  // Mirrors the neighbour table and registers, and keeps the route results
  // still owed by the block in order of the words that caused them.
  class route_scoreboard;
    bit                slot_used [NS];
    logic [AD-1:0]     slot_addr [NS];
    logic [PW-1:0]     slot_x [NS];
    logic [PW-1:0]     slot_y [NS];
    logic [AD-1:0]     own_addr;
    logic [PW-1:0]     own_x;
    logic [PW-1:0]     own_y;
    logic [SQ-1:0]     hop_sq;
    logic [SQ-1:0]     limit_sq;
    route_result_t     due_routes[$];
    int                errors;

    function new();
      foreach (slot_used[i]) begin
        slot_used[i] = 1'b0;
        slot_addr[i] = '0;
        slot_x[i] = '0;
        slot_y[i] = '0;
      end
      own_addr = '0;
      own_x = '0;
      own_y = '0;
      hop_sq = ggnh_pkg::HOP_RANGE_RESET;
      limit_sq = ggnh_pkg::SEARCH_LIMIT_RESET;
      errors = 0;
    endfunction

    function int pending();
      return due_routes.size();
    endfunction

    function void set_reg(input logic [ggnh_pkg::CFG_IDX_W-1:0] idx,
                          input logic [SQ-1:0] value);
      case (idx)
        ggnh_pkg::REG_SELF_ADDR: own_addr = value[AD-1:0];
        ggnh_pkg::REG_OWN_X: own_x = value[PW-1:0];
        ggnh_pkg::REG_OWN_Y: own_y = value[PW-1:0];
        ggnh_pkg::REG_HOP_RANGE_SQ: hop_sq = value;
        ggnh_pkg::REG_SEARCH_LIMIT_SQ: limit_sq = value;
        default: ;
      endcase
    endfunction

    function longint unsigned sq_dist(input logic [PW-1:0] ax, input logic [PW-1:0] ay,
                                      input logic [PW-1:0] bx, input logic [PW-1:0] by);
      longint unsigned dx;
      longint unsigned dy;
      dx = (ax > bx) ? longint'(ax - bx) : longint'(bx - ax);
      dy = (ay > by) ? longint'(ay - by) : longint'(by - ay);
      return dx * dx + dy * dy;
    endfunction

    function void note_input(input logic act, input logic [IW-1:0] idx,
                             input logic ent_valid, input logic [AD-1:0] addr,
                             input logic [PW-1:0] x, input logic [PW-1:0] y,
                             input logic [AD-1:0] dest);
      route_result_t   res;
      bit              known;
      bit              have_hop;
      logic [PW-1:0]   tx;
      logic [PW-1:0]   ty;
      longint unsigned best;
      longint unsigned d;
      res.status = ggnh_pkg::ST_WRITE_DONE;
      res.next_hop = '0;
      res.hop_found = 1'b0;
      if (act == ggnh_pkg::ACT_WRITE) begin
        slot_used[idx] = ent_valid;
        slot_addr[idx] = addr;
        slot_x[idx] = x;
        slot_y[idx] = y;
      end else begin
        known = 1'b0;
        tx = '0;
        ty = '0;
        // The highest matching slot gives the destination position.
        for (int i = 0; i < NS; i++) begin
          if (slot_used[i] && slot_addr[i] == dest) begin
            known = 1'b1;
            tx = slot_x[i];
            ty = slot_y[i];
          end
        end
        if (!known) begin
          res.status = ggnh_pkg::ST_UNKNOWN;
        end else begin
          have_hop = 1'b0;
          best = longint'(limit_sq);
          for (int i = 0; i < NS; i++) begin
            if (!slot_used[i] || slot_addr[i] == own_addr) continue;
            if (sq_dist(slot_x[i], slot_y[i], own_x, own_y) >= longint'(hop_sq)) continue;
            d = sq_dist(slot_x[i], slot_y[i], tx, ty);
            if (d < best) begin
              best = d;
              res.next_hop = slot_addr[i];
              have_hop = 1'b1;
            end
          end
          res.status = have_hop ? ggnh_pkg::ST_FOUND : ggnh_pkg::ST_NO_NEIGHBOR;
          res.hop_found = have_hop;
        end
      end
      due_routes.push_back(res);
    endfunction

    task report(input string msg);
      if (errors < PRINT_CAP) $display("ERROR: %s", msg);
      errors++;
    endtask

    task check_result(input logic [ggnh_pkg::STATUS_W-1:0] status,
                      input logic [AD-1:0] hop, input logic found);
      route_result_t want;
      if (due_routes.size() == 0) begin
        report($sformatf("result word with nothing outstanding: status %0d hop %h",
                         status, hop));
      end else begin
        want = due_routes.pop_front();
        if (status !== want.status)
          report($sformatf("status %0d, wanted %0d", status, want.status));
        if (hop !== want.next_hop)
          report($sformatf("next_hop %h, wanted %h", hop, want.next_hop));
        if (found !== want.hop_found)
          report($sformatf("hop_found %b, wanted %b", found, want.hop_found));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  wire  s_tready;
  logic [ggnh_pkg::IN_DATA_W-1:0] s_tdata = '0;
  logic [ggnh_pkg::IN_USER_W-1:0] s_tuser = '0;
  wire  m_tvalid;
  logic m_tready = 1'b0;
  wire  [ggnh_pkg::OUT_DATA_W-1:0] m_tdata;
  wire  [ggnh_pkg::OUT_USER_W-1:0] m_tuser;
  logic cfg_we = 1'b0;
  logic [ggnh_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [ggnh_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  route_scoreboard sb = new();
  bit tx_burst = 1'b0;
  bit rx_burst = 1'b0;
  bit hold_req = 1'b0;
  logic [AD-1:0] addr_pool [12];
  int idle_cycles = 0;

  greedy_geo_next_hop_core dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Outputs are sampled on the falling edge; a word seen with valid and
  // ready here is taken at the next rising edge.
  always @(negedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_result(m_tuser[1:0], m_tdata[AD-1:0], m_tuser[2]);
  end

  always @(negedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("ERROR: no word moved for %0d cycles", IDLE_LIMIT);
        $display("== FAIL ==");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Result side: a random stall before each word, and one long hold-off on
  // request so that the block backs up into its input.
  initial begin
    int stall;
    wait (!rst);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      stall = rx_burst ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(negedge clk);
      while (!m_tvalid) @(negedge clk);
      @(posedge clk);
    end
  end

  task automatic send_item(input logic act, input logic [IW-1:0] idx, input logic ent_valid,
                           input logic [AD-1:0] addr, input logic [PW-1:0] x,
                           input logic [PW-1:0] y, input logic [AD-1:0] dest);
    int gap;
    logic [ggnh_pkg::IN_DATA_W-1:0] word;
    gap = tx_burst ? 0 : $urandom_range(0, 11);
    word = '0;
    word[ggnh_pkg::IN_IDX_LSB +: IW] = idx;
    word[ggnh_pkg::IN_VALID_BIT] = ent_valid;
    word[ggnh_pkg::IN_ADDR_LSB +: AD] = addr;
    word[ggnh_pkg::IN_X_LSB +: PW] = x;
    word[ggnh_pkg::IN_Y_LSB +: PW] = y;
    word[ggnh_pkg::IN_DEST_LSB +: AD] = dest;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= word;
    s_tuser <= act;
    @(negedge clk);
    while (!s_tready) @(negedge clk);
    @(posedge clk);
    sb.note_input(act, idx, ent_valid, addr, x, y, dest);
  endtask

  task automatic write_reg(input logic [ggnh_pkg::CFG_IDX_W-1:0] idx,
                           input logic [SQ-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    sb.set_reg(idx, value);
    @(posedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic reconfigure(input logic [AD-1:0] own_a, input logic [PW-1:0] ox,
                             input logic [PW-1:0] oy, input logic [SQ-1:0] hop,
                             input logic [SQ-1:0] lim);
    int k;
    drain();
    write_reg(ggnh_pkg::REG_SELF_ADDR, SQ'(own_a));
    write_reg(ggnh_pkg::REG_OWN_X, SQ'(ox));
    write_reg(ggnh_pkg::REG_OWN_Y, SQ'(oy));
    write_reg(ggnh_pkg::REG_HOP_RANGE_SQ, hop);
    write_reg(ggnh_pkg::REG_SEARCH_LIMIT_SQ, lim);
    cfg_we <= 1'b0;
    // Addresses are mostly drawn from a small set so that queries hit the
    // table, duplicates occur and this node's own address turns up.
    addr_pool[0] = own_a;
    addr_pool[1] = '0;
    addr_pool[2] = '1;
    for (k = 3; k < 12; k++) addr_pool[k] = AD'($urandom_range(0, 16'hFFFF));
    @(posedge clk);
  endtask

  function automatic logic [PW-1:0] near(input logic [PW-1:0] centre, input int span);
    int v;
    if ($urandom_range(0, 99) < 15) return PW'($urandom_range(0, 16'hFFFF));
    v = int'(centre) + $urandom_range(0, 2 * span) - span;
    if (v < 0) v = 0;
    if (v > 16'hFFFF) v = 16'hFFFF;
    return v[PW-1:0];
  endfunction

  task automatic run_phase(input int count, input int span, input bit with_hold);
    logic          act;
    logic [AD-1:0] addr;
    logic [AD-1:0] dest;
    for (int n = 0; n < count; n++) begin
      if (with_hold && n == count / 2) hold_req = 1'b1;
      act = ($urandom_range(0, 99) < 45) ? ggnh_pkg::ACT_WRITE : ggnh_pkg::ACT_QUERY;
      addr = ($urandom_range(0, 99) < 85) ? addr_pool[$urandom_range(0, 11)]
                                          : AD'($urandom_range(0, 16'hFFFF));
      dest = ($urandom_range(0, 99) < 80) ? addr_pool[$urandom_range(0, 11)]
                                          : AD'($urandom_range(0, 16'hFFFF));
      send_item(act, IW'($urandom_range(0, NS - 1)), $urandom_range(0, 99) < 85, addr,
                near(sb.own_x, span), near(sb.own_y, span), dest);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed words under the reset settings: this node is address 0 at the
    // origin, hop range 1.0 and search limit 5.0.
    send_item(ggnh_pkg::ACT_QUERY, '1, 1'b1, '1, '1, '1, 16'h0000);          // empty table
    send_item(ggnh_pkg::ACT_WRITE, 5'd0, 1'b1, 16'd5, 16'd100, 16'd0, '1);
    send_item(ggnh_pkg::ACT_WRITE, 5'd31, 1'b1, '1, '1, '1, 16'd0);
    send_item(ggnh_pkg::ACT_WRITE, 5'd1, 1'b1, 16'd0, 16'd150, 16'd150, 16'd0); // own address
    send_item(ggnh_pkg::ACT_WRITE, 5'd2, 1'b0, 16'd7, 16'd20, 16'd0, 16'd0);  // invalid slot
    send_item(ggnh_pkg::ACT_QUERY, 5'd0, 1'b0, 16'd0, 16'd0, 16'd0, 16'd5);   // destination is hop
    send_item(ggnh_pkg::ACT_QUERY, 5'd0, 1'b0, 16'd0, 16'd0, 16'd0, 16'hFFFF);
    send_item(ggnh_pkg::ACT_QUERY, 5'd0, 1'b0, 16'd0, 16'd0, 16'd0, 16'd7);
    send_item(ggnh_pkg::ACT_WRITE, 5'd3, 1'b1, 16'd9, 16'd0, 16'd100, 16'd0);
    send_item(ggnh_pkg::ACT_WRITE, 5'd4, 1'b1, 16'd11, 16'd300, 16'd300, 16'd0);
    send_item(ggnh_pkg::ACT_QUERY, 5'd0, 1'b0, 16'd0, 16'd0, 16'd0, 16'd11);  // tie, lower slot
    send_item(ggnh_pkg::ACT_WRITE, 5'd6, 1'b1, 16'd11, 16'd120, 16'd0, 16'd0);
    send_item(ggnh_pkg::ACT_QUERY, 5'd0, 1'b0, 16'd0, 16'd0, 16'd0, 16'd11);  // last match wins
    send_item(ggnh_pkg::ACT_WRITE, 5'd8, 1'b1, 16'd20, 16'd256, 16'd0, 16'd0); // on the hop edge
    send_item(ggnh_pkg::ACT_QUERY, 5'd0, 1'b0, 16'd0, 16'd0, 16'd0, 16'd20);
    send_item(ggnh_pkg::ACT_WRITE, 5'd9, 1'b1, 16'd21, 16'd1380, 16'd0, 16'd0);
    send_item(ggnh_pkg::ACT_WRITE, 5'd6, 1'b0, 16'd11, 16'd120, 16'd0, 16'd0);
    send_item(ggnh_pkg::ACT_QUERY, 5'd0, 1'b0, 16'd0, 16'd0, 16'd0, 16'd21);  // exactly at limit
    send_item(ggnh_pkg::ACT_WRITE, 5'd0, 1'b0, 16'd5, 16'd100, 16'd0, 16'd0);
    send_item(ggnh_pkg::ACT_QUERY, 5'd0, 1'b0, 16'd0, 16'd0, 16'd0, 16'd5);
    send_item(ggnh_pkg::ACT_QUERY, 5'd0, 1'b0, 16'd0, 16'd0, 16'd0, 16'd11);
    send_item(ggnh_pkg::ACT_WRITE, 5'd0, 1'b1, 16'd5, 16'd100, 16'd0, 16'd0);

    reconfigure(AD'($urandom_range(0, 16'hFFFF)), 16'h4000, 16'h4000, 33'd262144,
                ggnh_pkg::SEARCH_LIMIT_RESET);
    run_phase(190, 700, 1'b1);

    tx_burst = 1'b1;
    rx_burst = 1'b1;
    reconfigure(16'h0000, 16'h0000, 16'h0000, 33'd0, '1);
    run_phase(190, 400, 1'b0);

    tx_burst = 1'b0;
    rx_burst = 1'b0;
    reconfigure(16'hFFFF, 16'hFFFF, 16'hFFFF, '1, '1);
    run_phase(190, 40000, 1'b0);

    tx_burst = 1'b1;
    reconfigure(AD'($urandom_range(0, 16'hFFFF)), PW'($urandom_range(0, 16'hFFFF)),
                PW'($urandom_range(0, 16'hFFFF)), 33'd1048576, 33'd0);
    run_phase(190, 600, 1'b0);

    tx_burst = 1'b0;
    rx_burst = 1'b1;
    reconfigure(AD'($urandom_range(0, 16'hFFFF)), PW'($urandom_range(0, 16'hFFFF)),
                PW'($urandom_range(0, 16'hFFFF)), SQ'($urandom_range(32'h10000, 32'h400000)),
                SQ'($urandom_range(32'h10000, 32'h1000000)));
    run_phase(190, 1500, 1'b0);

    drain();
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> greedy_geo_next_hop_core.f
src/ggnh_pkg.sv
src/ggnh_ram.sv
src/ggnh_ctrl.sv
src/ggnh_dpath.sv
src/greedy_geo_next_hop_core.sv
tb/sv/tb_top.sv
